### hw/rtl/hssp_pkg.sv
package hssp_pkg;

    localparam int POSITION_BITS_DEFAULT = 24;
    localparam int VALUE_BITS            = 24;
    localparam int INTERVAL_BITS         = 16;
    localparam int COIL_BITS             = 4;
    localparam int QUEUE_DEPTH           = 2;

    localparam logic [INTERVAL_BITS-1:0] STEP_INTERVAL_RESET = INTERVAL_BITS'(10);

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_TARGET = 2'd1,
        CMD_LOAD   = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TICK,
        OP_TARGET,
        OP_LOAD
    } op_kind_t;

    typedef struct packed {
        logic [1:0]                   cmd;
        logic signed [VALUE_BITS-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic [COIL_BITS-1:0]         coils;
        logic signed [VALUE_BITS-1:0] position;
        logic                         stepped;
        logic                         at_target;
    } rsp_item_t;

    typedef struct packed {
        op_kind_t                     kind;
        logic signed [VALUE_BITS-1:0] value;
    } op_t;

    function automatic logic [COIL_BITS-1:0] half_step_coils(input logic [2:0] phase);
        logic [COIL_BITS-1:0] pattern;
        unique case (phase)
            3'd0:    pattern = 4'h8;
            3'd1:    pattern = 4'hC;
            3'd2:    pattern = 4'h4;
            3'd3:    pattern = 4'h6;
            3'd4:    pattern = 4'h2;
            3'd5:    pattern = 4'h3;
            3'd6:    pattern = 4'h1;
            default: pattern = 4'h9;
        endcase
        return pattern;
    endfunction

endpackage

### hw/rtl/half_step_stepper_positioner_core.sv
// path: a command is written to the queue, then popped into the result register
// throughput: one item per cycle while the receiver does not stall; the position,
// target and interval counter update in the back end, behind a two-entry queue
// reset: asynchronous, active low; position, target and counter clear to zero,
// coils off, step interval 10, queue and result register empty
module half_step_stepper_positioner_core
    import hssp_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     interval_we,
    input  logic [INTERVAL_BITS-1:0] interval_data,
    input  logic                     cmd_valid,
    output logic                     cmd_stall,
    input  cmd_item_t                cmd_item,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output rsp_item_t                rsp_item
);

    logic queue_full;
    logic push;
    op_t  push_op;
    logic pop;
    logic queue_nonempty;
    op_t  pop_op;

    hssp_front u_front (
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_item   (cmd_item),
        .queue_full (queue_full),
        .push       (push),
        .push_op    (push_op)
    );

    hssp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_op  (push_op),
        .full     (queue_full),
        .pop      (pop),
        .nonempty (queue_nonempty),
        .pop_op   (pop_op)
    );

    hssp_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .interval_we   (interval_we),
        .interval_data (interval_data),
        .op_valid      (queue_nonempty),
        .op            (pop_op),
        .pop           (pop),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp_item      (rsp_item)
    );

endmodule

### hw/rtl/hssp_front.sv
module hssp_front
    import hssp_pkg::*;
(
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd_item,
    input  logic      queue_full,
    output logic      push,
    output op_t       push_op
);

    always_comb
    begin
        push_op.value = cmd_item.value;
        unique case (cmd_t'(cmd_item.cmd))
            CMD_TICK:   push_op.kind = OP_TICK;
            CMD_TARGET: push_op.kind = OP_TARGET;
            CMD_LOAD:   push_op.kind = OP_LOAD;
            default:    push_op.kind = OP_NONE;
        endcase
    end

    assign cmd_stall = queue_full;
    assign push      = cmd_valid && !queue_full;

endmodule

### hw/rtl/hssp_queue.sv
module hssp_queue
    import hssp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output logic nonempty,
    output op_t  pop_op
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    op_t              entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == FULL_COUNT);
    assign nonempty = (count_reg != '0);
    assign pop_op   = entries_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

### hw/rtl/hssp_back.sv
module hssp_back
    import hssp_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     interval_we,
    input  logic [INTERVAL_BITS-1:0] interval_data,
    input  logic                     op_valid,
    input  op_t                      op,
    output logic                     pop,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output rsp_item_t                rsp_item
);

    logic [INTERVAL_BITS-1:0]        interval_reg;
    logic signed [POSITION_BITS-1:0] pos_reg, pos_next;
    logic signed [POSITION_BITS-1:0] tgt_reg, tgt_next;
    logic [INTERVAL_BITS-1:0]        wait_reg, wait_next;
    logic [COIL_BITS-1:0]            coil_reg, coil_next;
    logic                            stepped_next;
    logic                            rsp_valid_reg;
    rsp_item_t                       rsp_item_reg;
    logic                            load_out;

    assign load_out  = !rsp_valid_reg || !rsp_stall;
    assign pop       = op_valid && load_out;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    always_comb
    begin
        logic [INTERVAL_BITS-1:0]        limit;
        logic [INTERVAL_BITS-1:0]        wait_inc;
        logic signed [POSITION_BITS-1:0] loaded;
        limit        = (interval_reg == '0) ? INTERVAL_BITS'(1) : interval_reg;
        wait_inc     = (wait_reg < limit) ? wait_reg + INTERVAL_BITS'(1) : wait_reg;
        loaded       = POSITION_BITS'(op.value);
        pos_next     = pos_reg;
        tgt_next     = tgt_reg;
        wait_next    = wait_reg;
        coil_next    = coil_reg;
        stepped_next = 1'b0;
        unique case (op.kind)
            OP_TICK:
            begin
                wait_next = wait_inc;
                if (wait_inc >= limit && pos_reg != tgt_reg)
                begin
                    coil_next    = half_step_coils(pos_reg[2:0]);
                    pos_next     = (tgt_reg > pos_reg) ? pos_reg + POSITION_BITS'(1)
                                                       : pos_reg - POSITION_BITS'(1);
                    wait_next    = '0;
                    stepped_next = 1'b1;
                end
            end
            OP_TARGET:
            begin
                tgt_next = loaded;
            end
            OP_LOAD:
            begin
                pos_next = loaded;
                tgt_next = loaded;
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= STEP_INTERVAL_RESET;
            pos_reg       <= '0;
            tgt_reg       <= '0;
            wait_reg      <= '0;
            coil_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (interval_we)
            begin
                interval_reg <= interval_data;
            end
            if (pop)
            begin
                pos_reg  <= pos_next;
                tgt_reg  <= tgt_next;
                wait_reg <= wait_next;
                coil_reg <= coil_next;
            end
            if (load_out)
            begin
                rsp_valid_reg <= op_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rsp_item_reg.coils     <= coil_next;
            rsp_item_reg.position  <= VALUE_BITS'(pos_next);
            rsp_item_reg.stepped   <= stepped_next;
            rsp_item_reg.at_target <= (pos_next == tgt_next);
        end
    end

endmodule

### hw/rtl/hssp_checker.sv
module hssp_checker
    import hssp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_stall,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input rsp_item_t rsp_item
);

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp_item))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_item.stepped |->
            ($countones(rsp_item.coils) == 1 || $countones(rsp_item.coils) == 2))
        else $error("step without a half-step coil pattern");

    assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !cmd_stall)
        else $error("input stalled with the result side empty");

endmodule

bind half_step_stepper_positioner_core hssp_checker u_hssp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
);

### tb/sv/tb_half_step_stepper_positioner_core.sv
module tb_half_step_stepper_positioner_core;
    timeunit 1ns;
    timeprecision 1ps;

    import hssp_pkg::*;

    localparam logic [COIL_BITS-1:0] PHASE_COILS [8] =
        '{4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};

    localparam int PHASE_COUNT = 7;
    localparam int PHASE_INTERVAL [PHASE_COUNT] = '{65535, 1, 3, 2, 10, 5, 1};
    localparam int PHASE_ITEMS [PHASE_COUNT]    = '{16, 90, 70, 70, 60, 60, 54};

    class position_scoreboard;
        logic [INTERVAL_BITS-1:0]     interval;
        logic signed [VALUE_BITS-1:0] position;
        logic signed [VALUE_BITS-1:0] target;
        logic [INTERVAL_BITS-1:0]     tick_count;
        logic [COIL_BITS-1:0]         coil_state;
        rsp_item_t                    awaited[$];
        int                           mismatches;

        function new();
            interval   = STEP_INTERVAL_RESET;
            position   = '0;
            target     = '0;
            tick_count = '0;
            coil_state = '0;
            mismatches = 0;
        endfunction

        function void note_command(cmd_item_t item);
            logic [INTERVAL_BITS-1:0] due;
            rsp_item_t                result;
            result.stepped = 1'b0;
            case (cmd_t'(item.cmd))
                CMD_TICK:
                begin
                    due = (interval == '0) ? INTERVAL_BITS'(1) : interval;
                    if (tick_count < due)
                        tick_count++;
                    if (tick_count >= due && position != target)
                    begin
                        coil_state = PHASE_COILS[position[2:0]];
                        if (target > position)
                            position++;
                        else
                            position--;
                        tick_count     = '0;
                        result.stepped = 1'b1;
                    end
                end
                CMD_TARGET:
                begin
                    target = item.value;
                end
                CMD_LOAD:
                begin
                    position = item.value;
                    target   = item.value;
                end
                default:
                begin
                end
            endcase
            result.coils     = coil_state;
            result.position  = position;
            result.at_target = (position == target);
            awaited.push_back(result);
        endfunction

        function void check_response(rsp_item_t got);
            rsp_item_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: coils %h position %0d stepped %b at_target %b",
                             got.coils, got.position, got.stepped, got.at_target);
                return;
            end
            want = awaited.pop_front();
            if (got.coils !== want.coils || got.position !== want.position ||
                got.stepped !== want.stepped || got.at_target !== want.at_target)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected coils %h position %0d stepped %b at_target %b, %s",
                             want.coils, want.position, want.stepped, want.at_target,
                             $sformatf("got coils %h position %0d stepped %b at_target %b",
                                       got.coils, got.position, got.stepped, got.at_target));
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     interval_we = 1'b0;
    logic [INTERVAL_BITS-1:0] interval_data = '0;
    logic                     cmd_valid = 1'b0;
    logic                     cmd_stall;
    cmd_item_t                cmd_item = '0;
    logic                     rsp_valid;
    logic                     rsp_stall = 1'b0;
    rsp_item_t                rsp_item;

    position_scoreboard board = new();
    cmd_item_t          cmd_plan[$];
    int                 stall_mode = 0;
    int                 stall_left = 0;

    half_step_stepper_positioner_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .interval_we   (interval_we),
        .interval_data (interval_data),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .cmd_item      (cmd_item),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp_item      (rsp_item)
    );

    always #5 clk = ~clk;

    // receiver stall pattern picks a new random mode whenever its countdown runs out
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 80);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= stall_left[1];
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_response(rsp_item);
    end

    task automatic plan_item(cmd_t code, logic [VALUE_BITS-1:0] value);
        cmd_item_t item;
        item.cmd   = code;
        item.value = value;
        cmd_plan.push_back(item);
    endtask

    // mostly load, set target, then ticks for the distance (at most 30); some noise
    task automatic plan_random(int count);
        int                      added;
        int                      off;
        int                      ticks;
        int                      due;
        logic [VALUE_BITS-1:0]   start;
        added = 0;
        due   = (board.interval == '0) ? 1 : int'(board.interval);
        while (added < count)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                case ($urandom_range(0, 5))
                    0:       start = VALUE_BITS'(24'h7FFFFF - $urandom_range(0, 6));
                    1:       start = VALUE_BITS'(24'h800000 + $urandom_range(0, 6));
                    2:       start = VALUE_BITS'($urandom_range(0, 12) - 6);
                    default: start = VALUE_BITS'($urandom);
                endcase
                off   = int'($urandom_range(0, 8)) - 4;
                ticks = (off < 0 ? -off : off) * due + int'($urandom_range(0, 3));
                if (ticks > 30)
                    ticks = 30;
                plan_item(CMD_LOAD, start);
                plan_item(CMD_TARGET, VALUE_BITS'(start + off));
                repeat (ticks)
                    plan_item(CMD_TICK, VALUE_BITS'($urandom));
                added += ticks + 2;
            end
            else
            begin
                plan_item(cmd_t'($urandom_range(0, 3)), VALUE_BITS'($urandom));
                added++;
            end
        end
    endtask

    // sends the plan in bursts with random gaps
    task automatic send_plan();
        cmd_item_t item;
        int        run_len;
        int        gap;
        while (cmd_plan.size() > 0)
        begin
            run_len = $urandom_range(1, 12);
            while (run_len > 0 && cmd_plan.size() > 0)
            begin
                item = cmd_plan.pop_front();
                cmd_valid <= 1'b1;
                cmd_item  <= item;
                @(posedge clk);
                while (cmd_stall)
                    @(posedge clk);
                board.note_command(item);
                run_len--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
        cmd_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (3)
            @(posedge clk);
    endtask

    task automatic write_interval(logic [INTERVAL_BITS-1:0] value);
        interval_we   <= 1'b1;
        interval_data <= value;
        @(posedge clk);
        interval_we <= 1'b0;
        board.interval = value;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(posedge clk);

        // reset interval, unused command, step near the positive extreme
        plan_item(CMD_TICK, 24'h7FFFFF);
        plan_item(CMD_UNUSED, 24'h800000);
        plan_item(CMD_LOAD, 24'h7FFFFF);
        plan_item(CMD_TARGET, 24'h7FFFFC);
        for (int i = 0; i < 9; i++)
            plan_item(CMD_TICK, (i % 2) ? 24'hFFFFFF : 24'h000000);
        send_plan();
        wait_drained();

        // zero interval, counter already due, negative positions
        write_interval('0);
        plan_item(CMD_TICK, 24'h000000);
        plan_item(CMD_TICK, 24'h000000);
        plan_item(CMD_TICK, 24'h000000);
        plan_item(CMD_LOAD, 24'h800000);
        plan_item(CMD_TARGET, 24'h800002);
        plan_item(CMD_TICK, 24'h555555);
        plan_item(CMD_TICK, 24'hAAAAAA);
        plan_item(CMD_TICK, 24'h000000);
        plan_item(CMD_LOAD, 24'hFFFFFF);
        plan_item(CMD_TARGET, 24'hFFFFFD);
        plan_item(CMD_TICK, 24'h000000);
        plan_item(CMD_TICK, 24'h000000);
        send_plan();
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_interval(INTERVAL_BITS'(PHASE_INTERVAL[p]));
            plan_random(PHASE_ITEMS[p] / 2);
            send_plan();
            wait_drained();
            plan_random(PHASE_ITEMS[p] - PHASE_ITEMS[p] / 2);
            send_plan();
            wait_drained();
        end

        if (board.mismatches == 0 && board.awaited.size() == 0)
            $display("tb_half_step_stepper_positioner_core OK");
        else
            $display("tb_half_step_stepper_positioner_core NOT OK");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb_half_step_stepper_positioner_core NOT OK");
        $finish;
    end

endmodule
